// ----- rtl/hltp_pkg.sv -----
// Shared types, constants and codes for the linear-probing hash table.
package hltp_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int KEY_CHARS_DEF = 30;
  localparam int CHAR_W        = 5;
  localparam int FIELD_CHARS   = 10;
  localparam int FIELD_W       = CHAR_W * FIELD_CHARS;
  localparam int MAX_CHARS     = 3 * FIELD_CHARS;
  localparam int KEY_W         = 3 * FIELD_W;
  localparam int VAL_W         = 32;
  localparam int SLOT_W        = 10;
  localparam int TS_W          = 11;
  localparam int MULT_W        = 10;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 11;
  localparam int STAT_W        = 2;
  localparam int RED_STEPS     = MULT_W;
  localparam int CNT_W         = $clog2(MAX_CHARS + 1);

  localparam logic [TS_W-1:0]   TS_RESET   = 11'd1024;
  localparam logic [MULT_W-1:0] MULT_RESET = 10'd31;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT       = 1'b1;

  localparam logic [1:0] ACT_GET  = 2'd0;
  localparam logic [1:0] ACT_PUT  = 2'd1;
  localparam logic [1:0] ACT_DEL  = 2'd2;
  localparam logic [1:0] ACT_RSVD = 2'd3;  // reserved, acts as get

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // slot state word: {occupied, tombstone}
  localparam logic [STAT_W-1:0] SLOT_EMPTY = 2'b00;
  localparam logic [STAT_W-1:0] SLOT_USED  = 2'b10;
  localparam logic [STAT_W-1:0] SLOT_TOMB  = 2'b01;

  typedef struct packed {
    logic [1:0]          action;
    logic [FIELD_W-1:0]  key_chars_first;
    logic [FIELD_W-1:0]  key_chars_middle;
    logic [FIELD_W-1:0]  key_chars_last;
    logic signed [31:0]  put_value;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   home_slot;
    logic                collided;
    logic [SLOT_W-1:0]   final_slot;
    logic [1:0]          status;
    logic signed [31:0]  read_value;
  } res_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic hash_mul;
    logic hash_red;
    logic probe_init;
    logic probe_eval;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic clear_done;
    logic key_end;
    logic red_last;
    logic probe_stop;
  } stat_t;

endpackage

// ----- rtl/hash_table_linear_probing_unit.sv -----
// Top level of the open-addressing hash table with linear probing.
// After reset the block sweeps the slot-state memory with busy high;
// configuration writes are taken during that sweep. A request
// is taken when start is high and busy is low. While busy is high it
// hashes the key characters (up to KEY_CHARS, ending at the first zero
// code) and then probes slots: each character costs one multiply step
// plus ten shift-subtract steps of the remainder unit, and each probe one
// registered memory read plus one compare. The result appears for one
// cycle with done high, in the same cycle that busy falls; the receiver
// cannot stall it, and a new request may start in that same cycle.
module hash_table_linear_probing_unit #(
  parameter int TABLE_DEPTH = hltp_pkg::DEPTH_DEF,
  parameter int KEY_CHARS   = hltp_pkg::KEY_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hltp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hltp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            start,
  input  hltp_pkg::req_t                  req,
  output logic                            busy,
  output logic                            done,
  output hltp_pkg::res_t                  res
);
  import hltp_pkg::*;

  ctl_t  ctl;   // controller commands
  stat_t stat;  // datapath status

  hltp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .ctl(ctl), .busy(busy), .done(done)
  );

  hltp_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_CHARS(KEY_CHARS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .req(req), .ctl(ctl), .stat(stat), .res(res)
  );

endmodule

// ----- rtl/hltp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hltp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/hltp_datapath.sv -----
// Datapath: config registers, hash remainder unit, probe walker, slot memories.
module hltp_datapath #(
  parameter int TABLE_DEPTH = hltp_pkg::DEPTH_DEF,
  parameter int KEY_CHARS   = hltp_pkg::KEY_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hltp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hltp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  hltp_pkg::req_t                    req,
  input  hltp_pkg::ctl_t                    ctl,
  output hltp_pkg::stat_t                   stat,
  output hltp_pkg::res_t                    res
);
  import hltp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int QW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (QW > TS_W) ? QW : TS_W;
  localparam int XW = QW + MULT_W;
  localparam int RW = $clog2(RED_STEPS);

  logic [TS_W-1:0]   table_size;
  logic [MULT_W-1:0] hash_multiplier;
  logic [QW-1:0]     q;
  logic [CW-1:0]     ts_e;

  logic [1:0]         act;
  logic [VAL_W-1:0]   pv;
  logic [KEY_W-1:0]   key_raw;
  logic [KEY_W-1:0]   key_sh;
  logic [KEY_W-1:0]   key_norm;
  logic [MAX_CHARS-1:0] keep;
  logic [CNT_W-1:0]   n;
  logic [CHAR_W-1:0]  c;

  logic [AW-1:0]      h;
  logic [AW-1:0]      w;
  logic [XW-1:0]      xh;
  logic [XW-1:0]      xw;
  logic [XW-1:0]      xh_s;
  logic [XW-1:0]      xw_s;
  logic [XW-1:0]      sub;
  logic [RW-1:0]      rs;
  logic [AW+CHAR_W-1:0] cw;
  logic [AW+MULT_W-1:0] wm;

  logic [AW-1:0]      pi;
  logic [QW-1:0]      pj;
  logic [QW-1:0]      pj_inc;
  logic [QW-1:0]      pi_inc;
  logic [AW-1:0]      pi_wrap;
  logic               found;
  logic               has_free;
  logic [AW-1:0]      fs;
  logic [AW-1:0]      fin;
  logic               coll;
  logic [VAL_W-1:0]   hit_val;
  logic [AW-1:0]      clr;

  logic [KEY_W-1:0]   key_rd;
  logic [VAL_W-1:0]   val_rd;
  logic [STAT_W-1:0]  st_rd;
  logic               occ;
  logic               tomb;
  logic               match;

  logic               key_we;
  logic               val_we;
  logic               st_we;
  logic [AW-1:0]      waddr;
  logic [VAL_W-1:0]   val_wd;
  logic [STAT_W-1:0]  st_wd;

  // size in use: 0 acts as 1, above the depth acts as the depth
  assign ts_e = CW'(table_size);
  always_comb begin
    if (table_size == '0) begin
      q = QW'(1);
    end else if (ts_e > CW'(TABLE_DEPTH)) begin
      q = QW'(TABLE_DEPTH);
    end else begin
      q = QW'(ts_e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size      <= TS_RESET;
      hash_multiplier <= MULT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TABLE_SIZE: table_size      <= cfg_wdata;
        CFG_MULT:       hash_multiplier <= MULT_W'(cfg_wdata);
        default:        ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_CHARS; k++) begin
      key_norm[k*CHAR_W +: CHAR_W] = keep[k] ? key_raw[k*CHAR_W +: CHAR_W] : '0;
    end
  end

  assign c             = key_sh[CHAR_W-1:0];
  assign stat.key_end  = (c == '0) || (n == CNT_W'(KEY_CHARS));
  assign stat.red_last = (rs == '0);
  assign cw            = c * w;
  assign wm            = w * hash_multiplier;

  // one restoring subtract step per cycle on each remainder
  assign sub  = XW'(q) << rs;
  assign xh_s = (xh >= sub) ? xh - sub : xh;
  assign xw_s = (xw >= sub) ? xw - sub : xw;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      act     <= req.action;
      pv      <= req.put_value;
      key_raw <= {req.key_chars_last, req.key_chars_middle, req.key_chars_first};
      key_sh  <= {req.key_chars_last, req.key_chars_middle, req.key_chars_first};
      keep    <= '0;
      n       <= '0;
      h       <= '0;
      w       <= AW'(q != QW'(1));
    end
    if (ctl.hash_mul) begin
      xh      <= XW'(h) + XW'(cw);
      xw      <= XW'(wm);
      rs      <= RW'(RED_STEPS - 1);
      keep[n[$clog2(MAX_CHARS)-1:0]] <= 1'b1;
    end
    if (ctl.hash_red) begin
      xh <= xh_s;
      xw <= xw_s;
      rs <= rs - 1'b1;
      if (rs == '0) begin
        h      <= AW'(xh_s);
        w      <= AW'(xw_s);
        key_sh <= key_sh >> CHAR_W;
        n      <= n + 1'b1;
      end
    end
  end

  // probe walk
  assign occ     = st_rd[1];
  assign tomb    = st_rd[0];
  assign match   = (key_rd == key_norm);
  assign pj_inc  = pj + 1'b1;
  assign pi_inc  = QW'(pi) + 1'b1;
  assign pi_wrap = (pi_inc >= q) ? '0 : AW'(pi_inc);
  assign stat.probe_stop = (occ && match) || (!occ && !tomb) || (pj_inc == q);

  always_ff @(posedge clk) begin
    if (ctl.probe_init) begin
      pi       <= h;
      pj       <= '0;
      found    <= 1'b0;
      has_free <= 1'b0;
    end
    if (ctl.probe_eval) begin
      if (pj == '0) begin
        coll <= tomb || (occ && !match);
      end
      if (occ && match) begin
        found   <= 1'b1;
        fin     <= pi;
        hit_val <= val_rd;
      end else begin
        if (!occ && !has_free) begin
          has_free <= 1'b1;
          fs       <= pi;
        end
        if (!occ && !tomb) begin
          fin <= pi;
        end else begin
          pi  <= pi_wrap;
          pj  <= pj_inc;
          fin <= pi_wrap;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (ctl.clear_step) begin
      clr <= clr + 1'b1;
    end
  end
  assign stat.clear_done = (clr == AW'(TABLE_DEPTH - 1));

  // commit and result
  always_comb begin
    key_we = 1'b0;
    val_we = 1'b0;
    st_we  = 1'b0;
    waddr  = fin;
    val_wd = pv;
    st_wd  = SLOT_EMPTY;
    if (ctl.clear_step) begin
      st_we = 1'b1;
      waddr = clr;
    end else if (ctl.finish) begin
      if (act == ACT_PUT) begin
        if (found) begin
          val_we = 1'b1;
        end else if (has_free) begin
          key_we = 1'b1;
          val_we = 1'b1;
          st_we  = 1'b1;
          st_wd  = SLOT_USED;
          waddr  = fs;
        end
      end else if (act == ACT_DEL) begin
        if (found) begin
          st_we = 1'b1;
          st_wd = SLOT_TOMB;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      res.home_slot  <= SLOT_W'(h);
      res.collided   <= coll;
      res.final_slot <= SLOT_W'(fin);
      res.status     <= found ? ST_OK : ST_MISS;
      res.read_value <= '0;
      if (act == ACT_PUT) begin
        if (found) begin
          res.read_value <= pv;
        end else if (has_free) begin
          res.final_slot <= SLOT_W'(fs);
          res.status     <= ST_INSERTED;
          res.read_value <= pv;
        end else begin
          res.final_slot <= SLOT_W'(h);
          res.status     <= ST_OVERFLOW;
        end
      end else if (act != ACT_DEL && found) begin
        res.read_value <= hit_val;
      end
    end
  end

  hltp_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(key_norm), .raddr(pi), .rdata(key_rd)
  );

  hltp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(waddr), .wdata(val_wd), .raddr(pi), .rdata(val_rd)
  );

  hltp_ram #(.WIDTH(STAT_W), .DEPTH(TABLE_DEPTH)) u_st_ram (
    .clk(clk), .we(st_we), .waddr(waddr), .wdata(st_wd), .raddr(pi), .rdata(st_rd)
  );

endmodule

// ----- rtl/hltp_ctrl.sv -----
// Controller: request sequencing over clear, hash, probe and commit phases.
module hltp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  hltp_pkg::stat_t stat,
  output hltp_pkg::ctl_t  ctl,
  output logic            busy,
  output logic            done
);
  import hltp_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HCHAR = 7'b0000100,
    S_HRED  = 7'b0001000,
    S_PRD   = 7'b0010000,
    S_PCMP  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clear_done) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_HCHAR;
      S_HCHAR: state_next = stat.key_end ? S_PRD : S_HRED;
      S_HRED:  if (stat.red_last) state_next = S_HCHAR;
      S_PRD:   state_next = S_PCMP;
      S_PCMP:  state_next = stat.probe_stop ? S_FIN : S_PRD;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
    end
  end

  assign busy           = (state != S_IDLE);
  assign ctl.clear_step = (state == S_CLEAR);
  assign ctl.load       = (state == S_IDLE) && start;
  assign ctl.hash_mul   = (state == S_HCHAR) && !stat.key_end;
  assign ctl.probe_init = (state == S_HCHAR) && stat.key_end;
  assign ctl.hash_red   = (state == S_HRED);
  assign ctl.probe_eval = (state == S_PCMP);
  assign ctl.finish     = (state == S_FIN);

endmodule

// ----- rtl/hltp_checker.sv -----
// Port-level checker for the hash table, bound to the top level.
module hltp_port_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input hltp_pkg::res_t res
);
  import hltp_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request taken but busy stayed low");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back results");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done) else $error("result right after reset");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    done && res.status == ST_OVERFLOW |-> res.read_value == 0 &&
    res.final_slot == res.home_slot) else $error("bad overflow result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && res.status == ST_MISS |-> res.read_value == 0)
    else $error("miss with nonzero value");

endmodule

bind hash_table_linear_probing_unit hltp_port_checker u_hltp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);

// ----- test/hltp_checker.sv -----
// Request/result checker for the linear-probing hash table: predicts and compares.
`timescale 1ns / 1ps
module hltp_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hltp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hltp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            start,
  input  logic                            busy,
  input  hltp_pkg::req_t                  req,
  input  logic                            done,
  input  hltp_pkg::res_t                  res,
  output int                              fails,
  output int                              pending
);
  import hltp_pkg::*;

  localparam int NSLOT = 1024;

  logic [TS_W-1:0]   size_reg;
  logic [MULT_W-1:0] mult_reg;
  logic [KEY_W-1:0]  slot_key [NSLOT];
  logic [31:0]       slot_val [NSLOT];
  logic              slot_used [NSLOT];
  logic              slot_dead [NSLOT];
  res_t              due_q [$];

  assign pending = due_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
    fails++;
  endtask

  // works out one result and updates the table copy
  function automatic res_t lookup_update(input req_t r);
    logic [KEY_W-1:0] raw, key;
    int q, w, h, c, i, fin, free_at;
    bit stop, found, has_free;
    res_t o;
    raw = {r.key_chars_last, r.key_chars_middle, r.key_chars_first};
    key = '0;
    q = (size_reg == 0) ? 1 : (size_reg > NSLOT) ? NSLOT : int'(size_reg);
    w = 1 % q;
    h = 0;
    stop = 0;
    for (int n = 0; n < MAX_CHARS; n++) begin
      c = raw[n*CHAR_W +: CHAR_W];
      if (c == 0) stop = 1;
      if (stop) c = 0;
      key[n*CHAR_W +: CHAR_W] = c[CHAR_W-1:0];
      h = (h + c * w) % q;
      w = (w * int'(mult_reg)) % q;
    end
    o = '0;
    o.home_slot = h[SLOT_W-1:0];
    o.collided = slot_dead[h] || (slot_used[h] && slot_key[h] != key);
    // probe walk
    i = h; found = 0; has_free = 0; free_at = 0; fin = -1;
    for (int j = 0; j < q && fin < 0; j++) begin
      if (slot_used[i]) begin
        if (slot_key[i] == key) begin
          found = 1;
          fin = i;
        end
      end else begin
        if (!has_free) begin
          has_free = 1;
          free_at = i;
        end
        if (!slot_dead[i]) fin = i;
      end
      if (fin < 0) i = (i + 1 >= q) ? 0 : i + 1;
    end
    if (fin < 0) fin = i;
    if (r.action == ACT_PUT) begin
      if (found) begin
        slot_val[fin] = r.put_value;
        o.status = ST_OK;
        o.read_value = r.put_value;
      end else if (has_free) begin
        fin = free_at;
        slot_key[fin] = key;
        slot_val[fin] = r.put_value;
        slot_used[fin] = 1;
        slot_dead[fin] = 0;
        o.status = ST_INSERTED;
        o.read_value = r.put_value;
      end else begin
        fin = h;
        o.status = ST_OVERFLOW;
      end
    end else if (r.action == ACT_DEL) begin
      if (found) begin
        slot_used[fin] = 0;
        slot_dead[fin] = 1;
        o.status = ST_OK;
      end else o.status = ST_MISS;
    end else begin
      // get, and the reserved code that acts as get
      if (found) begin
        o.status = ST_OK;
        o.read_value = slot_val[fin];
      end else o.status = ST_MISS;
    end
    o.final_slot = fin[SLOT_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      fails = 0;
      for (int s = 0; s < NSLOT; s++) begin
        slot_used[s] = 0;
        slot_dead[s] = 0;
      end
      size_reg = TS_RESET;
      mult_reg = MULT_RESET;
    end else begin
      if (done) begin
        if (due_q.size() == 0) report("unexpected result", res, 0);
        else begin
          want = due_q.pop_front();
          if (res.home_slot != want.home_slot) report("home_slot", res.home_slot, want.home_slot);
          if (res.collided != want.collided) report("collided", res.collided, want.collided);
          if (res.final_slot != want.final_slot)
            report("final_slot", res.final_slot, want.final_slot);
          if (res.status != want.status) report("status", res.status, want.status);
          if (res.read_value != want.read_value)
            report("read_value", res.read_value, want.read_value);
        end
      end
      if (start && !busy) due_q.push_back(lookup_update(req));
      if (cfg_we) begin
        if (cfg_index == CFG_TABLE_SIZE) size_reg = cfg_wdata[TS_W-1:0];
        else mult_reg = cfg_wdata[MULT_W-1:0];
      end
    end
  end
endmodule

// ----- test/testbench.sv -----
// Stimulus and verdict for the linear-probing hash table.
`timescale 1ns / 1ps
module testbench;
  import hltp_pkg::*;

  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int PHASE_ITEMS = 240;

  logic clk, rst, cfg_we, start;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  req_t req;
  res_t res;
  logic busy, done;
  int fails, pending;
  longint cycles = 0;
  int sent, idle_pct;
  logic [KEY_W-1:0] key_pool [8];

  hash_table_linear_probing_unit dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_wdata, .start, .req, .busy, .done, .res
  );

  hltp_checker chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_wdata, .start, .busy, .req, .done, .res,
    .fails, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // random key: mostly short, sometimes full length or with codes 27..31;
  // junk after the terminator exercises normalization
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    int len;
    for (int n = 0; n < MAX_CHARS; n++) k[n*CHAR_W +: CHAR_W] = CHAR_W'($urandom);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_CHARS) : $urandom_range(1, 5);
    for (int n = 0; n < len; n++)
      k[n*CHAR_W +: CHAR_W] = ($urandom_range(0, 15) == 0) ? CHAR_W'($urandom_range(27, 31))
                                                          : CHAR_W'($urandom_range(1, 26));
    if (len < MAX_CHARS) begin
      k[len*CHAR_W +: CHAR_W] = '0;
      if ($urandom_range(0, 1))
        for (int n = len + 1; n < MAX_CHARS; n++) k[n*CHAR_W +: CHAR_W] = '0;
    end
    return k;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // wait until all expected results are in and the block is idle
  task automatic drain();
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // hold the request until the block takes it
  task automatic issue(input logic [1:0] act, input logic [KEY_W-1:0] k, input logic [31:0] v);
    start <= 1;
    req <= '{act, k[FIELD_W-1:0], k[2*FIELD_W-1:FIELD_W], k[KEY_W-1:2*FIELD_W], v};
    do @(posedge clk); while (busy);
    sent++;
    if ($urandom_range(1, 100) <= idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic quiet();
    start <= 0;
    @(posedge clk);
  endtask

  int sizes [8] = '{1024, 4, 1, 2047, 0, 16, 1024, 8};
  int mults [8] = '{31, 0, 1023, 7, 5, 1023, 0, 2};
  int rates [8] = '{0, 61, 0, 26, 61, 0, 61, 26};

  initial begin
    logic [KEY_W-1:0] ka, kb, kfull, khigh;
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_wdata = '0; start = 0; req = '0;
    sent = 0; idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    drain();

    // directed: default config, then a one-slot table
    ka = rand_key();
    for (int n = 0; n < MAX_CHARS; n++) kfull[n*CHAR_W +: CHAR_W] = 5'd26;
    for (int n = 0; n < MAX_CHARS; n++) khigh[n*CHAR_W +: CHAR_W] = 5'd31;
    issue(ACT_PUT, '0, 32'h8000_0000);           // empty key
    issue(ACT_PUT, kfull, 32'h7fff_ffff);
    issue(ACT_PUT, khigh, 32'hffff_ffff);
    issue(ACT_GET, kfull, 0);
    issue(ACT_GET, '0, 0);
    issue(ACT_GET, ka, 0);                       // miss
    issue(ACT_PUT, kfull, 32'h1234_5678);        // update
    issue(ACT_DEL, kfull, 0);
    issue(ACT_GET, kfull, 0);                    // passes the tombstone
    issue(ACT_DEL, kfull, 0);                    // delete of absent key
    issue(ACT_PUT, kfull, 32'h0);                // reuse of tombstone
    issue(ACT_RSVD, khigh, 0);                   // reserved action
    quiet();
    drain();
    write_reg(CFG_TABLE_SIZE, 1);
    write_reg(CFG_MULT, 1023);
    kb = rand_key();
    while (kb == ka) kb = rand_key();
    issue(ACT_PUT, ka, 1);
    issue(ACT_PUT, kb, 2);                       // overflow
    issue(ACT_DEL, ka, 0);
    issue(ACT_GET, ka, 0);                       // walks the whole table
    issue(ACT_PUT, kb, 3);
    issue(ACT_GET, kb, 0);
    quiet();
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_TABLE_SIZE, sizes[p]);
      write_reg(CFG_MULT, mults[p]);
      idle_pct = rates[p];
      for (int i = 0; i < 8; i++) key_pool[i] = rand_key();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        logic [KEY_W-1:0] k;
        logic [1:0] act;
        k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)] : rand_key();
        act = ($urandom_range(0, 19) == 0) ? ACT_RSVD : 2'($urandom_range(0, 2));
        issue(act, k, $urandom);
      end
      quiet();
      drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d requests over 10 table size/multiplier settings", sent);
    $display("incl. overflow, tombstone reuse, out-of-range sizes and reserved action");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/hltp_pkg.sv
rtl/hltp_ram.sv
rtl/hltp_datapath.sv
rtl/hltp_ctrl.sv
rtl/hash_table_linear_probing_unit.sv
rtl/hltp_checker.sv
test/hltp_checker.sv
test/testbench.sv
